@@ rtl/rvdec_pkg.sv @@
// Shared types and codes for the RV32IMF instruction decoder.
`default_nettype none

package rvdec_pkg;

    // Result kind codes
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_INSTR   = 2'd0;
    localparam t_kind KIND_UNKNOWN = 2'd1;
    localparam t_kind KIND_DATA    = 2'd2;

    // Major opcodes, bits 6..2 of the word
    typedef logic [4:0] t_opc;
    localparam t_opc OPC_LOAD    = 5'h00;
    localparam t_opc OPC_LOAD_FP = 5'h01;
    localparam t_opc OPC_OP_IMM  = 5'h04;
    localparam t_opc OPC_AUIPC   = 5'h05;
    localparam t_opc OPC_STORE   = 5'h08;
    localparam t_opc OPC_STOREFP = 5'h09;
    localparam t_opc OPC_OP      = 5'h0C;
    localparam t_opc OPC_LUI     = 5'h0D;
    localparam t_opc OPC_MADD    = 5'h10;
    localparam t_opc OPC_MSUB    = 5'h11;
    localparam t_opc OPC_NMSUB   = 5'h12;
    localparam t_opc OPC_NMADD   = 5'h13;
    localparam t_opc OPC_OP_FP   = 5'h14;
    localparam t_opc OPC_BRANCH  = 5'h18;
    localparam t_opc OPC_JALR    = 5'h19;
    localparam t_opc OPC_JAL     = 5'h1B;

    // funct7 codes
    typedef logic [6:0] t_f7;
    localparam t_f7 F7_BASE  = 7'h00;
    localparam t_f7 F7_MULDV = 7'h01;
    localparam t_f7 F7_ALT   = 7'h20;
    localparam t_f7 F7_FADD  = 7'h00;
    localparam t_f7 F7_FSUB  = 7'h04;
    localparam t_f7 F7_FMUL  = 7'h08;
    localparam t_f7 F7_FDIV  = 7'h0C;
    localparam t_f7 F7_FSQRT = 7'h2C;
    localparam t_f7 F7_FSGNJ = 7'h10;
    localparam t_f7 F7_FMNMX = 7'h14;
    localparam t_f7 F7_FCVTW = 7'h60;
    localparam t_f7 F7_FMVXW = 7'h70;
    localparam t_f7 F7_FCMP  = 7'h50;
    localparam t_f7 F7_FCVTS = 7'h68;
    localparam t_f7 F7_FMVWX = 7'h78;

    // Mnemonic numbers
    typedef logic [6:0] t_mnem;
    localparam t_mnem MN_NONE     = 7'd0;
    localparam t_mnem MN_LUI      = 7'd1;
    localparam t_mnem MN_AUIPC    = 7'd2;
    localparam t_mnem MN_ADDI     = 7'd3;
    localparam t_mnem MN_SLTI     = 7'd4;
    localparam t_mnem MN_SLTIU    = 7'd5;
    localparam t_mnem MN_XORI     = 7'd6;
    localparam t_mnem MN_ORI      = 7'd7;
    localparam t_mnem MN_ANDI     = 7'd8;
    localparam t_mnem MN_SLLI     = 7'd9;
    localparam t_mnem MN_SRLI     = 7'd10;
    localparam t_mnem MN_SRAI     = 7'd11;
    localparam t_mnem MN_ADD      = 7'd12;
    localparam t_mnem MN_SUB      = 7'd13;
    localparam t_mnem MN_MUL      = 7'd14;
    localparam t_mnem MN_SLL      = 7'd15;
    localparam t_mnem MN_MULH     = 7'd16;
    localparam t_mnem MN_SLT      = 7'd17;
    localparam t_mnem MN_MULHSU   = 7'd18;
    localparam t_mnem MN_SLTU     = 7'd19;
    localparam t_mnem MN_MULHU    = 7'd20;
    localparam t_mnem MN_XOR      = 7'd21;
    localparam t_mnem MN_DIV      = 7'd22;
    localparam t_mnem MN_SRL      = 7'd23;
    localparam t_mnem MN_SRA      = 7'd24;
    localparam t_mnem MN_DIVU     = 7'd25;
    localparam t_mnem MN_OR       = 7'd26;
    localparam t_mnem MN_REM      = 7'd27;
    localparam t_mnem MN_AND      = 7'd28;
    localparam t_mnem MN_REMU     = 7'd29;
    localparam t_mnem MN_LB       = 7'd30;
    localparam t_mnem MN_LH       = 7'd31;
    localparam t_mnem MN_LW       = 7'd32;
    localparam t_mnem MN_LBU      = 7'd33;
    localparam t_mnem MN_LHU      = 7'd34;
    localparam t_mnem MN_SB       = 7'd35;
    localparam t_mnem MN_SH       = 7'd36;
    localparam t_mnem MN_SW       = 7'd37;
    localparam t_mnem MN_JAL      = 7'd38;
    localparam t_mnem MN_JALR     = 7'd39;
    localparam t_mnem MN_BEQ      = 7'd40;
    localparam t_mnem MN_BNE      = 7'd41;
    localparam t_mnem MN_BLT      = 7'd42;
    localparam t_mnem MN_BGE      = 7'd43;
    localparam t_mnem MN_BLTU     = 7'd44;
    localparam t_mnem MN_BGEU     = 7'd45;
    localparam t_mnem MN_FMADD_S  = 7'd46;
    localparam t_mnem MN_FADD_S   = 7'd50;
    localparam t_mnem MN_FSUB_S   = 7'd51;
    localparam t_mnem MN_FMUL_S   = 7'd52;
    localparam t_mnem MN_FDIV_S   = 7'd53;
    localparam t_mnem MN_FSQRT_S  = 7'd54;
    localparam t_mnem MN_FSGNJ_S  = 7'd55;
    localparam t_mnem MN_FSGNJN_S = 7'd56;
    localparam t_mnem MN_FSGNJX_S = 7'd57;
    localparam t_mnem MN_FMIN_S   = 7'd58;
    localparam t_mnem MN_FMAX_S   = 7'd59;
    localparam t_mnem MN_FCVT_W_S = 7'd60;
    localparam t_mnem MN_FCVT_WU_S = 7'd61;
    localparam t_mnem MN_FMV_X_W  = 7'd62;
    localparam t_mnem MN_FEQ_S    = 7'd63;
    localparam t_mnem MN_FLT_S    = 7'd64;
    localparam t_mnem MN_FLE_S    = 7'd65;
    localparam t_mnem MN_FCVT_S_W = 7'd66;
    localparam t_mnem MN_FCVT_S_WU = 7'd67;
    localparam t_mnem MN_FMV_W_X  = 7'd68;
    localparam t_mnem MN_FLW      = 7'd69;
    localparam t_mnem MN_FSW      = 7'd70;

    // One decoded result item
    typedef struct packed {
        t_kind              kind;
        t_mnem              mnemonic;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic [4:0]         src3_reg;
        logic signed [31:0] immediate;
        logic               end_marker;
        logic [31:0]        data_word;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/rv32imf_instruction_decoder_top.sv @@
// Top level of the RV32IMF instruction decoder: input register, decode, result register.
//
// Channel   Dir  tdata                          tuser   tlast
// s_axis    in   instr_word[31:0]               -       -
// m_axis    out  mnemonic..data_word, 96 bits   kind    end_marker
//
// One item per cycle unless stalled; the input register feeds the result register.
// The critical path is the opcode/funct decode between the two registers.
// Reset clears both valid flags and returns to the instruction section.
// A stalled result holds in the output register; the input register still
// takes one more item, and the input side stalls only when both are full.
`default_nettype none

module rv32imf_instruction_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // instr_word[31:0]
    input  wire logic [31:0] i_s_axis_tdata,
    input  wire logic        i_s_axis_tvalid,
    output      logic        o_s_axis_tready,
    // mnemonic[6:0], dest_reg[11:7], src1_reg[16:12], src2_reg[21:17],
    // src3_reg[26:22], immediate[58:27], data_word[90:59], zero[95:91]
    output      logic [95:0] o_m_axis_tdata,
    // kind[1:0]
    output      logic [1:0]  o_m_axis_tuser,
    // end_marker
    output      logic        o_m_axis_tlast,
    output      logic        o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready
);
    import rvdec_pkg::*;

    logic        r_in_valid;
    logic [31:0] r_in_word;
    logic        r_out_valid;
    t_result     r_out;
    logic        r_data_section;
    t_result     dec_result;
    logic        advance;

    // The input register moves on when the result register is free or drains
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;

    rvdec_decode u_decode (
        .i_data_section (r_data_section),
        .i_word         (r_in_word),
        .o_result       (dec_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_word <= i_s_axis_tdata;
        end
    end

    // Result register and section flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_data_section <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid && dec_result.end_marker) begin
                r_data_section <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= dec_result;
        end
    end

    // Output packing
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.end_marker;
    assign o_m_axis_tdata  = {5'd0, r_out.data_word, r_out.immediate,
                              r_out.src3_reg, r_out.src2_reg, r_out.src1_reg,
                              r_out.dest_reg, r_out.mnemonic};

    // Once in the data section, only reset leaves it
    a_section_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_data_section |=> r_data_section)
        else $error("data section flag dropped without reset");

    // An end marker result has already switched the section
    a_end_sets_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.end_marker) |->
            (r_data_section && r_out.kind == KIND_INSTR && r_out.mnemonic == MN_JAL))
        else $error("end marker without section switch");

    // Unrecognized words carry no mnemonic and no immediate
    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_UNKNOWN) |->
            (r_out.mnemonic == MN_NONE && r_out.immediate == 32'sd0))
        else $error("unknown word with mnemonic or immediate");

    // A data word only follows an end marker
    a_data_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_DATA) |-> r_data_section)
        else $error("data word outside data section");

endmodule

`default_nettype wire

@@ rtl/rvdec_decode.sv @@
// Combinational decode of one instruction word into a result item.
`default_nettype none

module rvdec_decode (
    input  wire logic              i_data_section,
    input  wire logic [31:0]       i_word,
    output rvdec_pkg::t_result     o_result
);
    import rvdec_pkg::*;

    logic [4:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [31:0] i_imm;
    logic [31:0] s_imm;
    logic [31:0] b_imm;
    logic [31:0] j_imm;
    logic [31:0] u_imm;
    logic [31:0] sh_imm;
    t_mnem       mn;
    logic [31:0] imm;
    logic        is_end;

    // Field slices and format immediates
    assign opc    = i_word[6:2];
    assign f3     = i_word[14:12];
    assign f7     = i_word[31:25];
    assign rd     = i_word[11:7];
    assign rs2    = i_word[24:20];
    assign i_imm  = {{20{i_word[31]}}, i_word[31:20]};
    assign s_imm  = {{20{i_word[31]}}, i_word[31:25], i_word[11:7]};
    assign b_imm  = {{19{i_word[31]}}, i_word[31], i_word[7], i_word[30:25],
                     i_word[11:8], 1'b0};
    assign j_imm  = {{11{i_word[31]}}, i_word[31], i_word[19:12], i_word[20],
                     i_word[30:21], 1'b0};
    assign u_imm  = {i_word[31:12], 12'h000};
    assign sh_imm = {27'd0, rs2};

    // Mnemonic and immediate select
    always_comb begin
        mn  = MN_NONE;
        imm = 32'd0;
        if (i_word[1:0] == 2'b11) begin
            case (opc)
                OPC_LUI: begin
                    mn  = MN_LUI;
                    imm = u_imm;
                end
                OPC_AUIPC: begin
                    mn  = MN_AUIPC;
                    imm = u_imm;
                end
                OPC_OP_IMM: begin
                    case (f3)
                        3'd0: mn = MN_ADDI;
                        3'd1: mn = (f7 == F7_BASE) ? MN_SLLI : MN_NONE;
                        3'd2: mn = MN_SLTI;
                        3'd3: mn = MN_SLTIU;
                        3'd4: mn = MN_XORI;
                        3'd5: begin
                            if (f7 == F7_BASE) mn = MN_SRLI;
                            else if (f7 == F7_ALT) mn = MN_SRAI;
                            else mn = MN_NONE;
                        end
                        3'd6: mn = MN_ORI;
                        default: mn = MN_ANDI;
                    endcase
                    // shifts carry the shift amount, the rest the I immediate
                    if (mn == MN_NONE) imm = 32'd0;
                    else if (f3 == 3'd1 || f3 == 3'd5) imm = sh_imm;
                    else imm = i_imm;
                end
                OPC_OP: begin
                    if (f7 == F7_BASE) begin
                        case (f3)
                            3'd0: mn = MN_ADD;
                            3'd1: mn = MN_SLL;
                            3'd2: mn = MN_SLT;
                            3'd3: mn = MN_SLTU;
                            3'd4: mn = MN_XOR;
                            3'd5: mn = MN_SRL;
                            3'd6: mn = MN_OR;
                            default: mn = MN_AND;
                        endcase
                    end else if (f7 == F7_MULDV) begin
                        case (f3)
                            3'd0: mn = MN_MUL;
                            3'd1: mn = MN_MULH;
                            3'd2: mn = MN_MULHSU;
                            3'd3: mn = MN_MULHU;
                            3'd4: mn = MN_DIV;
                            3'd5: mn = MN_DIVU;
                            3'd6: mn = MN_REM;
                            default: mn = MN_REMU;
                        endcase
                    end else if (f7 == F7_ALT) begin
                        if (f3 == 3'd0) mn = MN_SUB;
                        else if (f3 == 3'd5) mn = MN_SRA;
                        else mn = MN_NONE;
                    end
                end
                OPC_LOAD: begin
                    case (f3)
                        3'd0: mn = MN_LB;
                        3'd1: mn = MN_LH;
                        3'd2: mn = MN_LW;
                        3'd4: mn = MN_LBU;
                        3'd5: mn = MN_LHU;
                        default: mn = MN_NONE;
                    endcase
                    imm = (mn == MN_NONE) ? 32'd0 : i_imm;
                end
                OPC_STORE: begin
                    case (f3)
                        3'd0: mn = MN_SB;
                        3'd1: mn = MN_SH;
                        3'd2: mn = MN_SW;
                        default: mn = MN_NONE;
                    endcase
                    imm = (mn == MN_NONE) ? 32'd0 : s_imm;
                end
                OPC_BRANCH: begin
                    case (f3)
                        3'd0: mn = MN_BEQ;
                        3'd1: mn = MN_BNE;
                        3'd4: mn = MN_BLT;
                        3'd5: mn = MN_BGE;
                        3'd6: mn = MN_BLTU;
                        3'd7: mn = MN_BGEU;
                        default: mn = MN_NONE;
                    endcase
                    imm = (mn == MN_NONE) ? 32'd0 : b_imm;
                end
                OPC_JAL: begin
                    mn  = MN_JAL;
                    imm = j_imm;
                end
                OPC_JALR: begin
                    if (f3 == 3'd0) begin
                        mn  = MN_JALR;
                        imm = i_imm;
                    end
                end
                OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
                    // fused forms need single-precision format bits
                    if (i_word[26:25] == 2'b00) mn = MN_FMADD_S + {5'd0, opc[1:0]};
                end
                OPC_OP_FP: begin
                    case (f7)
                        F7_FADD:  mn = MN_FADD_S;
                        F7_FSUB:  mn = MN_FSUB_S;
                        F7_FMUL:  mn = MN_FMUL_S;
                        F7_FDIV:  mn = MN_FDIV_S;
                        F7_FSQRT: mn = (rs2 == 5'd0) ? MN_FSQRT_S : MN_NONE;
                        F7_FSGNJ: begin
                            case (f3)
                                3'd0: mn = MN_FSGNJ_S;
                                3'd1: mn = MN_FSGNJN_S;
                                3'd2: mn = MN_FSGNJX_S;
                                default: mn = MN_NONE;
                            endcase
                        end
                        F7_FMNMX: begin
                            case (f3)
                                3'd0: mn = MN_FMIN_S;
                                3'd1: mn = MN_FMAX_S;
                                default: mn = MN_NONE;
                            endcase
                        end
                        F7_FCVTW: begin
                            case (rs2)
                                5'd0: mn = MN_FCVT_W_S;
                                5'd1: mn = MN_FCVT_WU_S;
                                default: mn = MN_NONE;
                            endcase
                        end
                        F7_FMVXW: begin
                            mn = (f3 == 3'd0 && rs2 == 5'd0) ? MN_FMV_X_W : MN_NONE;
                        end
                        F7_FCMP: begin
                            case (f3)
                                3'd0: mn = MN_FLE_S;
                                3'd1: mn = MN_FLT_S;
                                3'd2: mn = MN_FEQ_S;
                                default: mn = MN_NONE;
                            endcase
                        end
                        F7_FCVTS: begin
                            case (rs2)
                                5'd0: mn = MN_FCVT_S_W;
                                5'd1: mn = MN_FCVT_S_WU;
                                default: mn = MN_NONE;
                            endcase
                        end
                        F7_FMVWX: begin
                            mn = (f3 == 3'd0 && rs2 == 5'd0) ? MN_FMV_W_X : MN_NONE;
                        end
                        default: mn = MN_NONE;
                    endcase
                end
                OPC_LOAD_FP: begin
                    if (f3 == 3'd2) begin
                        mn  = MN_FLW;
                        imm = i_imm;
                    end
                end
                OPC_STOREFP: begin
                    if (f3 == 3'd2) begin
                        mn  = MN_FSW;
                        imm = s_imm;
                    end
                end
                default: begin
                    mn  = MN_NONE;
                    imm = 32'd0;
                end
            endcase
        end
    end

    // JAL x0 with zero offset ends the instruction section
    assign is_end = (mn == MN_JAL) && (rd == 5'd0) && (imm == 32'd0);

    // Assemble the result; data words carry only the echoed word
    always_comb begin
        o_result           = '0;
        o_result.data_word = i_word;
        if (i_data_section) begin
            o_result.kind = KIND_DATA;
        end else begin
            o_result.kind       = (mn == MN_NONE) ? KIND_UNKNOWN : KIND_INSTR;
            o_result.mnemonic   = mn;
            o_result.dest_reg   = rd;
            o_result.src1_reg   = i_word[19:15];
            o_result.src2_reg   = rs2;
            o_result.src3_reg   = i_word[31:27];
            o_result.immediate  = imm;
            o_result.end_marker = is_end;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_rv32imf_instruction_decoder_top.sv @@
// Self-checking testbench for the RV32IMF instruction decoder stream block.
`default_nettype none

module tb_rv32imf_instruction_decoder_top;
    import rvdec_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_INSTRS  = 800;
    localparam int RANDOM_DATA    = 40;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 64;
    localparam int MAX_REPORTS    = 40;

    localparam logic [31:0] END_MARK_WORD = 32'h0000_006F;

    // funct3 and rs2 selector codes used by the decode
    localparam logic [2:0] F3_BASE = 3'd0;
    localparam logic [2:0] F3_SHL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_SHR  = 3'd5;
    localparam logic [4:0] RS2_SIGNED   = 5'd0;
    localparam logic [4:0] RS2_UNSIGNED = 5'd1;

    // mnemonic not named in the package
    localparam t_mnem MNEM_FNMADD_S = 7'd49;

    // funct3-indexed mnemonic lookups, index 7 listed first
    localparam logic [7:0][6:0] IMM_BY_F3 = {MN_ANDI, MN_ORI, MN_NONE, MN_XORI,
                                             MN_SLTIU, MN_SLTI, MN_NONE, MN_ADDI};
    localparam logic [7:0][6:0] BASE_BY_F3 = {MN_AND, MN_OR, MN_SRL, MN_XOR,
                                              MN_SLTU, MN_SLT, MN_SLL, MN_ADD};
    localparam logic [7:0][6:0] MULDV_BY_F3 = {MN_REMU, MN_REM, MN_DIVU, MN_DIV,
                                               MN_MULHU, MN_MULHSU, MN_MULH, MN_MUL};
    localparam logic [7:0][6:0] LOAD_BY_F3 = {MN_NONE, MN_NONE, MN_LHU, MN_LBU,
                                              MN_NONE, MN_LW, MN_LH, MN_LB};
    localparam logic [7:0][6:0] STORE_BY_F3 = {MN_NONE, MN_NONE, MN_NONE, MN_NONE,
                                               MN_NONE, MN_SW, MN_SH, MN_SB};
    localparam logic [7:0][6:0] BRANCH_BY_F3 = {MN_BGEU, MN_BLTU, MN_BGE, MN_BLT,
                                                MN_NONE, MN_NONE, MN_BNE, MN_BEQ};
    localparam logic [7:0][6:0] SGNJ_BY_F3 = {MN_NONE, MN_NONE, MN_NONE, MN_NONE,
                                              MN_NONE, MN_FSGNJX_S, MN_FSGNJN_S,
                                              MN_FSGNJ_S};
    localparam logic [7:0][6:0] MINMAX_BY_F3 = {MN_NONE, MN_NONE, MN_NONE, MN_NONE,
                                                MN_NONE, MN_NONE, MN_FMAX_S, MN_FMIN_S};
    localparam logic [7:0][6:0] FCMP_BY_F3 = {MN_NONE, MN_NONE, MN_NONE, MN_NONE,
                                              MN_NONE, MN_FEQ_S, MN_FLT_S, MN_FLE_S};

    // funct7 values the random words lean toward
    localparam logic [13:0][6:0] F7_CHOICES = {F7_FMVWX, F7_FCVTS, F7_FCMP, F7_FMVXW,
                                               F7_FCVTW, F7_FMNMX, F7_FSGNJ, F7_FSQRT,
                                               F7_FDIV, F7_FMUL, F7_FSUB, F7_ALT,
                                               F7_MULDV, F7_BASE};

    // One planned input item; fixed rows carry a typed-in expectation
    typedef struct packed {
        logic [31:0]        word;
        logic               tail;
        logic               fixed;
        t_kind              kind;
        t_mnem              mnem;
        logic signed [31:0] imm;
        logic               endm;
    } t_plan_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic [31:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [95:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;

    t_plan_item directed_rows[$];
    t_plan_item word_plan[$];
    t_result    pending_results[$];
    bit         in_data_section = 1'b0;
    bit         mnem_seen [0:127];
    int         mismatches = 0;
    int         items_in = 0;
    int         results_out = 0;
    int         unknown_seen = 0;
    int         data_seen = 0;
    int         input_stalls = 0;
    int         quiet_cycles = 0;

    rv32imf_instruction_decoder_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Instruction decode without section state: mnemonic plus format immediate
    function automatic t_mnem decode_instr(input logic [31:0] w,
                                           output logic signed [31:0] imm);
        t_opc               op;
        logic [2:0]         f3;
        t_f7                f7;
        logic [4:0]         rs2;
        logic signed [31:0] i_imm;
        logic signed [31:0] s_imm;
        logic signed [31:0] b_imm;
        logic signed [31:0] j_imm;
        t_mnem              mn;
        op    = w[6:2];
        f3    = w[14:12];
        f7    = w[31:25];
        rs2   = w[24:20];
        i_imm = {{20{w[31]}}, w[31:20]};
        s_imm = {{20{w[31]}}, w[31:25], w[11:7]};
        b_imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        j_imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        mn    = MN_NONE;
        imm   = '0;
        if (w[1:0] == 2'b11) begin
            case (op)
                OPC_LUI: begin
                    mn  = MN_LUI;
                    imm = {w[31:12], 12'b0};
                end
                OPC_AUIPC: begin
                    mn  = MN_AUIPC;
                    imm = {w[31:12], 12'b0};
                end
                OPC_OP_IMM: begin
                    // shifts carry the shift amount, the rest an I immediate
                    if (f3 == F3_SHL) begin
                        mn = (f7 == F7_BASE) ? MN_SLLI : MN_NONE;
                    end else if (f3 == F3_SHR) begin
                        mn = (f7 == F7_BASE) ? MN_SRLI : (f7 == F7_ALT) ? MN_SRAI : MN_NONE;
                    end else begin
                        mn = IMM_BY_F3[f3];
                    end
                    if (mn == MN_SLLI || mn == MN_SRLI || mn == MN_SRAI) begin
                        imm = {27'b0, rs2};
                    end else if (mn != MN_NONE) begin
                        imm = i_imm;
                    end
                end
                OPC_OP: begin
                    if (f7 == F7_BASE) begin
                        mn = BASE_BY_F3[f3];
                    end else if (f7 == F7_MULDV) begin
                        mn = MULDV_BY_F3[f3];
                    end else if (f7 == F7_ALT) begin
                        mn = (f3 == F3_BASE) ? MN_SUB : (f3 == F3_SHR) ? MN_SRA : MN_NONE;
                    end
                end
                OPC_LOAD: begin
                    mn  = LOAD_BY_F3[f3];
                    imm = (mn != MN_NONE) ? i_imm : '0;
                end
                OPC_STORE: begin
                    mn  = STORE_BY_F3[f3];
                    imm = (mn != MN_NONE) ? s_imm : '0;
                end
                OPC_BRANCH: begin
                    mn  = BRANCH_BY_F3[f3];
                    imm = (mn != MN_NONE) ? b_imm : '0;
                end
                OPC_JAL: begin
                    mn  = MN_JAL;
                    imm = j_imm;
                end
                OPC_JALR: begin
                    if (f3 == F3_BASE) begin
                        mn  = MN_JALR;
                        imm = i_imm;
                    end
                end
                OPC_MADD, OPC_MSUB, OPC_NMSUB, OPC_NMADD: begin
                    // single-precision format only
                    if (w[26:25] == 2'b00) mn = t_mnem'(MN_FMADD_S + t_mnem'(op - OPC_MADD));
                end
                OPC_OP_FP: begin
                    case (f7)
                        F7_FADD:  mn = MN_FADD_S;
                        F7_FSUB:  mn = MN_FSUB_S;
                        F7_FMUL:  mn = MN_FMUL_S;
                        F7_FDIV:  mn = MN_FDIV_S;
                        F7_FSQRT: mn = (rs2 == '0) ? MN_FSQRT_S : MN_NONE;
                        F7_FSGNJ: mn = SGNJ_BY_F3[f3];
                        F7_FMNMX: mn = MINMAX_BY_F3[f3];
                        F7_FCMP:  mn = FCMP_BY_F3[f3];
                        F7_FCVTW: begin
                            mn = (rs2 == RS2_SIGNED) ? MN_FCVT_W_S :
                                 (rs2 == RS2_UNSIGNED) ? MN_FCVT_WU_S : MN_NONE;
                        end
                        F7_FCVTS: begin
                            mn = (rs2 == RS2_SIGNED) ? MN_FCVT_S_W :
                                 (rs2 == RS2_UNSIGNED) ? MN_FCVT_S_WU : MN_NONE;
                        end
                        F7_FMVXW: mn = (f3 == F3_BASE && rs2 == '0) ? MN_FMV_X_W : MN_NONE;
                        F7_FMVWX: mn = (f3 == F3_BASE && rs2 == '0) ? MN_FMV_W_X : MN_NONE;
                        default:  mn = MN_NONE;
                    endcase
                end
                OPC_LOAD_FP: begin
                    if (f3 == F3_WORD) begin
                        mn  = MN_FLW;
                        imm = i_imm;
                    end
                end
                OPC_STOREFP: begin
                    if (f3 == F3_WORD) begin
                        mn  = MN_FSW;
                        imm = s_imm;
                    end
                end
                default: mn = MN_NONE;
            endcase
        end
        return mn;
    endfunction

    // Expected result for one accepted word; tracks the data section
    function automatic t_result predict_result(input logic [31:0] w);
        t_result            r;
        t_mnem              mn;
        logic signed [31:0] imm;
        r           = '0;
        r.data_word = w;
        if (in_data_section) begin
            r.kind = KIND_DATA;
            return r;
        end
        mn          = decode_instr(w, imm);
        r.kind      = (mn == MN_NONE) ? KIND_UNKNOWN : KIND_INSTR;
        r.mnemonic  = mn;
        r.dest_reg  = w[11:7];
        r.src1_reg  = w[19:15];
        r.src2_reg  = w[24:20];
        r.src3_reg  = w[31:27];
        r.immediate = imm;
        if (mn == MN_JAL && w[11:7] == '0 && imm == '0) begin
            r.end_marker    = 1'b1;
            in_data_section = 1'b1;
        end
        return r;
    endfunction

    // Random word that decodes to the wanted mnemonic (opcode forced, rest retried)
    function automatic logic [31:0] shape_word(input t_mnem target);
        logic [31:0]        w;
        logic signed [31:0] scratch_imm;
        t_opc               op;
        int                 tries;
        if (target == MN_LUI)            op = OPC_LUI;
        else if (target == MN_AUIPC)     op = OPC_AUIPC;
        else if (target <= MN_SRAI)      op = OPC_OP_IMM;
        else if (target <= MN_REMU)      op = OPC_OP;
        else if (target <= MN_LHU)       op = OPC_LOAD;
        else if (target <= MN_SW)        op = OPC_STORE;
        else if (target == MN_JAL)       op = OPC_JAL;
        else if (target == MN_JALR)      op = OPC_JALR;
        else if (target <= MN_BGEU)      op = OPC_BRANCH;
        else if (target < MN_FADD_S)     op = t_opc'(OPC_MADD + t_opc'(target - MN_FMADD_S));
        else if (target <= MN_FMV_W_X)   op = OPC_OP_FP;
        else if (target == MN_FLW)       op = OPC_LOAD_FP;
        else                             op = OPC_STOREFP;
        w = '0;
        for (tries = 0; tries < 4000; tries++) begin
            w      = $urandom;
            w[1:0] = 2'b11;
            w[6:2] = op;
            if ($urandom_range(0, 1) == 0) w[31:25] = F7_CHOICES[$urandom_range(0, 13)];
            if ($urandom_range(0, 2) == 0) w[24:20] = 5'($urandom_range(0, 1));
            if (decode_instr(w, scratch_imm) == target) break;
        end
        return w;
    endfunction

    function automatic void add_row(input logic tail, input logic [31:0] w,
                                    input logic fixed, input t_kind kind,
                                    input t_mnem mnem, input logic signed [31:0] imm,
                                    input logic endm);
        t_plan_item p;
        p = '{word: w, tail: tail, fixed: fixed, kind: kind, mnem: mnem, imm: imm,
              endm: endm};
        directed_rows.push_back(p);
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("result %0d: %s is %h, expected %h", results_out, field, got, want);
    endtask

    // Stimulus plan: directed head, random instructions, end marker tail, data words
    task automatic build_plan();
        t_plan_item  p;
        logic [31:0] w;
        int          i;
        // tail, word, fixed, kind, mnemonic, immediate, end
        add_row(1'b0, 32'h0000_0000, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'hFFFF_FFFF, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'hFFFF_F037, 1'b1, KIND_INSTR,   MN_LUI,        -4096,    1'b0);
        add_row(1'b0, 32'h0000_0017, 1'b1, KIND_INSTR,   MN_AUIPC,      0,        1'b0);
        add_row(1'b0, 32'h8000_0013, 1'b1, KIND_INSTR,   MN_ADDI,       -2048,    1'b0);
        add_row(1'b0, 32'h7FF0_0013, 1'b1, KIND_INSTR,   MN_ADDI,       2047,     1'b0);
        add_row(1'b0, 32'h0200_1013, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'h41F0_5013, 1'b1, KIND_INSTR,   MN_SRAI,       31,       1'b0);
        add_row(1'b0, 32'h8000_0063, 1'b1, KIND_INSTR,   MN_BEQ,        -4096,    1'b0);
        add_row(1'b0, 32'h7E00_7FE3, 1'b1, KIND_INSTR,   MN_BGEU,       4094,     1'b0);
        add_row(1'b0, 32'h8000_00EF, 1'b1, KIND_INSTR,   MN_JAL,        -1048576, 1'b0);
        add_row(1'b0, 32'h0020_006F, 1'b0, KIND_INSTR,   MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'h0000_1067, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'hFE00_2FA3, 1'b1, KIND_INSTR,   MN_SW,         -1,       1'b0);
        add_row(1'b0, 32'h0000_3003, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'h0400_0033, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'h5810_0053, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'hF000_1053, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'hF000_0053, 1'b1, KIND_INSTR,   MN_FMV_W_X,    0,        1'b0);
        add_row(1'b0, 32'h0200_0043, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'hF800_004F, 1'b1, KIND_INSTR,   MNEM_FNMADD_S, 0,        1'b0);
        add_row(1'b0, 32'h8000_2007, 1'b1, KIND_INSTR,   MN_FLW,        -2048,    1'b0);
        add_row(1'b0, 32'h0000_0027, 1'b1, KIND_UNKNOWN, MN_NONE,       0,        1'b0);
        add_row(1'b0, 32'hD015_0553, 1'b0, KIND_INSTR,   MN_NONE,       0,        1'b0);
        add_row(1'b1, END_MARK_WORD, 1'b1, KIND_INSTR,   MN_JAL,        0,        1'b1);
        add_row(1'b1, 32'hFFFF_FFFF, 1'b1, KIND_DATA,    MN_NONE,       0,        1'b0);
        add_row(1'b1, END_MARK_WORD, 1'b1, KIND_DATA,    MN_NONE,       0,        1'b0);
        add_row(1'b1, 32'h8000_0013, 1'b1, KIND_DATA,    MN_NONE,       0,        1'b0);

        foreach (directed_rows[i]) if (!directed_rows[i].tail) word_plan.push_back(directed_rows[i]);

        // mostly well-formed words of a random mnemonic, some noise and broken ones
        for (i = 0; i < RANDOM_INSTRS; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2: w = $urandom;
                3, 4: begin
                    w = shape_word(t_mnem'($urandom_range(MN_LUI, MN_FSW)));
                    w[$urandom_range(0, 31)] ^= 1'b1;
                end
                default: w = shape_word(t_mnem'($urandom_range(MN_LUI, MN_FSW)));
            endcase
            // the end marker is kept for the tail
            if (w == END_MARK_WORD) w[7] = 1'b1;
            p = '0;
            p.word = w;
            word_plan.push_back(p);
        end

        foreach (directed_rows[i]) if (directed_rows[i].tail) word_plan.push_back(directed_rows[i]);

        for (i = 0; i < RANDOM_DATA; i++) begin
            p = '0;
            p.word = $urandom;
            word_plan.push_back(p);
        end
    endtask

    // Sender, then end-of-run checks
    initial begin : main_seq
        t_result want;
        int      idx;
        int      gap;
        int      burst;
        int      covered;
        int      m;
        idx     = 0;
        covered = 0;
        build_plan();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        while (idx < word_plan.size()) begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 16);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst = $urandom_range(1, 40);
            while (burst != 0 && idx < word_plan.size()) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= word_plan[idx].word;
                @(posedge i_clk);
                while (!o_s_axis_tready) begin
                    input_stalls++;
                    @(posedge i_clk);
                end
                // item taken: queue what the decoder must return for it
                want = predict_result(word_plan[idx].word);
                if (word_plan[idx].fixed) begin
                    want.kind       = word_plan[idx].kind;
                    want.mnemonic   = word_plan[idx].mnem;
                    want.immediate  = word_plan[idx].imm;
                    want.end_marker = word_plan[idx].endm;
                end
                pending_results.push_back(want);
                items_in++;
                idx++;
                burst--;
                @(negedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        for (m = MN_LUI; m <= MN_FSW; m++) if (mnem_seen[m]) covered++;
        $display("run: %0d words in, %0d results out, %0d of 70 mnemonics decoded",
                 items_in, results_out, covered);
        $display("run: %0d unknown words, %0d data words, %0d cycles of input backpressure",
                 unknown_seen, data_seen, input_stalls);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver: phases of random stalling, plus one long hold-off to fill the block
    initial begin : receiver
        int phase_left = 0;
        int ready_pct = 100;
        int hold_left = 0;
        bit hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && items_in >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 75;
                        2:       ready_pct = 40;
                        default: ready_pct = 10;
                    endcase
                    phase_left = $urandom_range(10, 120);
                end
                phase_left--;
                i_m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // Result check against the oldest pending expectation
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind       = o_m_axis_tuser;
            got.mnemonic   = o_m_axis_tdata[6:0];
            got.dest_reg   = o_m_axis_tdata[11:7];
            got.src1_reg   = o_m_axis_tdata[16:12];
            got.src2_reg   = o_m_axis_tdata[21:17];
            got.src3_reg   = o_m_axis_tdata[26:22];
            got.immediate  = o_m_axis_tdata[58:27];
            got.data_word  = o_m_axis_tdata[90:59];
            got.end_marker = o_m_axis_tlast;
            results_out++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no word pending", got.data_word, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                if (got.mnemonic !== want.mnemonic)
                    report_mismatch("mnemonic", 32'(got.mnemonic), 32'(want.mnemonic));
                if (got.dest_reg !== want.dest_reg)
                    report_mismatch("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
                if (got.src1_reg !== want.src1_reg)
                    report_mismatch("src1_reg", 32'(got.src1_reg), 32'(want.src1_reg));
                if (got.src2_reg !== want.src2_reg)
                    report_mismatch("src2_reg", 32'(got.src2_reg), 32'(want.src2_reg));
                if (got.src3_reg !== want.src3_reg)
                    report_mismatch("src3_reg", 32'(got.src3_reg), 32'(want.src3_reg));
                if (got.immediate !== want.immediate)
                    report_mismatch("immediate", got.immediate, want.immediate);
                if (got.end_marker !== want.end_marker)
                    report_mismatch("end_marker", 32'(got.end_marker),
                                    32'(want.end_marker));
                if (got.data_word !== want.data_word)
                    report_mismatch("data_word", got.data_word, want.data_word);
                if (o_m_axis_tdata[95:91] !== '0)
                    report_mismatch("tdata padding", 32'(o_m_axis_tdata[95:91]), '0);
                mnem_seen[want.mnemonic] = 1'b1;
                if (want.kind == KIND_UNKNOWN) unknown_seen++;
                if (want.kind == KIND_DATA) data_seen++;
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles, %0d results pending",
                         quiet_cycles, pending_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/rvdec_pkg.sv
rtl/rvdec_decode.sv
rtl/rv32imf_instruction_decoder_top.sv
tb/tb_rv32imf_instruction_decoder_top.sv
